FILE: src/dssm_pkg.sv
// Shared types and constants for the dual stack shared memory unit.
`timescale 1ns / 1ps

package dssm_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2,
    STS_RSVD      = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture the request word
    logic exec;       // memory access and count update
    logic load_out;   // move result into the output register
  } dssm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register empty or emptying this cycle
  } dssm_sts_t;

endpackage

FILE: src/dssm_ctrl.sv
// Request sequencer: accept, execute, hand result to output register.
`timescale 1ns / 1ps

module dssm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output dssm_pkg::dssm_cmd_t cmd,
  input  dssm_pkg::dssm_sts_t sts
);
  import dssm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.exec)
    else $error("accepted request not executed next cycle");
  a_no_load_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded into a busy output register");

endmodule

FILE: src/dssm_datapath.sv
// Stack datapath: shared memory, stack counts, capacity and result register.
`timescale 1ns / 1ps

module dssm_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dssm_pkg::dssm_cmd_t        cmd,
  output dssm_pkg::dssm_sts_t        sts,
  input  logic [1:0]                 req_action,
  input  logic                       req_sel,
  input  logic signed [dssm_pkg::DATA_W-1:0] req_value,
  input  logic                       cfg_valid,
  input  logic [dssm_pkg::CNT_W-1:0] cfg_data,
  input  logic                       out_tready,
  output logic                       out_valid,
  output logic signed [dssm_pkg::DATA_W-1:0] out_read_value,
  output logic [1:0]                 out_status,
  output logic                       out_low_empty,
  output logic                       out_high_empty,
  output logic                       out_shared_full
);
  import dssm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;

  action_t                  act_r;
  logic                     sel_r;
  logic signed [DATA_W-1:0] val_r;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] low_cnt_r, low_cnt_nxt;
  logic [CNT_W-1:0] high_cnt_r, high_cnt_nxt;
  status_t          status_r, status_nxt;
  logic             from_mem_r;
  logic             out_valid_r;

  logic [CNT_W-1:0] eff_cap, used, sel_cnt, hi_push_idx, hi_top_idx, lo_top_idx;
  logic             is_full, wr_en, rd_en;
  logic [ADDR_W-1:0] addr;

  // capacity above the array size is clamped
  assign eff_cap     = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;
  assign used        = low_cnt_r + high_cnt_r;
  assign is_full     = (used >= eff_cap);
  assign sel_cnt     = sel_r ? high_cnt_r : low_cnt_r;
  assign hi_push_idx = eff_cap - CNT_W'(1) - high_cnt_r;
  assign hi_top_idx  = eff_cap - high_cnt_r;
  assign lo_top_idx  = low_cnt_r - CNT_W'(1);

  always_comb begin
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    addr         = '0;
    status_nxt   = STS_OK;
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    case (act_r)
      ACT_PUSH: begin
        if (is_full) begin
          status_nxt = STS_OVERFLOW;
        end else begin
          wr_en = 1'b1;
          if (sel_r) begin
            addr         = hi_push_idx[ADDR_W-1:0];
            high_cnt_nxt = high_cnt_r + CNT_W'(1);
          end else begin
            addr        = low_cnt_r[ADDR_W-1:0];
            low_cnt_nxt = low_cnt_r + CNT_W'(1);
          end
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (sel_cnt == '0) begin
          status_nxt = STS_UNDERFLOW;
        end else begin
          rd_en = 1'b1;
          addr  = sel_r ? hi_top_idx[ADDR_W-1:0] : lo_top_idx[ADDR_W-1:0];
          if (act_r == ACT_POP) begin
            if (sel_r) high_cnt_nxt = high_cnt_r - CNT_W'(1);
            else       low_cnt_nxt  = low_cnt_r - CNT_W'(1);
          end
        end
      end
      default: ;  // unused code: no operation
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[addr] <= val_r;
    if (cmd.exec && rd_en) mem_q_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r <= action_t'(req_action);
      sel_r <= req_sel;
      val_r <= req_value;
    end
    if (cmd.exec) begin
      status_r   <= status_nxt;
      from_mem_r <= rd_en;
    end
    if (cmd.load_out) begin
      out_read_value  <= from_mem_r ? mem_q_r : '0;
      out_status      <= status_r;
      out_low_empty   <= (low_cnt_r == '0);
      out_high_empty  <= (high_cnt_r == '0);
      out_shared_full <= is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(DEPTH);
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        // a new capacity moves the high stack base, so both stacks empty
        cap_r      <= cfg_data;
        low_cnt_r  <= '0;
        high_cnt_r <= '0;
      end else if (cmd.exec) begin
        low_cnt_r  <= low_cnt_nxt;
        high_cnt_r <= high_cnt_nxt;
      end
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_tready;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) used <= eff_cap)
    else $error("stack counts exceed capacity");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !cfg_valid && act_r == ACT_PUSH && !is_full)
      |=> used == $past(used) + CNT_W'(1))
    else $error("successful push did not grow fill");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !cfg_valid && act_r == ACT_POP && sel_cnt != '0)
      |=> used == $past(used) - CNT_W'(1))
    else $error("successful pop did not shrink fill");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status != STS_RSVD)
    else $error("reserved status code on output");

endmodule

FILE: src/dual_stack_shared_memory_unit.sv
// Top level of the dual stack shared memory unit.
`timescale 1ns / 1ps
// Two stacks in one 64-word array: the low stack grows up from entry 0,
// the high stack grows down from capacity-1.
// Input channel in_*: one request per transfer (push, pop or peek on the
// stack chosen by in_tuser). Result channel out_*: one result per request,
// carrying the word read, status and the empty/full flags after the step.
// Configuration channel cfg_*: writes the capacity (1..64; larger values
// act as 64, zero gives no slots) and empties both stacks; cfg_ready is
// always high, write only while no request is in flight.
// Timing: a request is accepted in the idle cycle, the memory access
// happens the next cycle, and the result is registered in the response
// state once the output register is free; a request passes the request
// register, the registered array read and the output register in turn.
// The output register lets the next request be accepted while a result
// waits; if the receiver keeps stalling, the second result holds the
// sequencer and in_tready stays low until out_tready frees the register.
// Reset (rst_n low, synchronous): stacks empty, capacity 64, no result
// pending. Array contents are not cleared; only pushed entries are read.

module dual_stack_shared_memory_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] action, [33:2] push_value, [39:34] zero
  input  logic [0:0]  in_tuser,   // [0] stack_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [33:32] status, [34] low_empty,
                                  // [35] high_empty, [36] shared_full, [39:37] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // capacity
);
  import dssm_pkg::*;

  dssm_cmd_t cmd;
  dssm_sts_t sts;

  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic                     low_empty, high_empty, shared_full;

  assign cfg_ready = 1'b1;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dssm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .req_action      (in_tdata[1:0]),
    .req_sel         (in_tuser[0]),
    .req_value       (in_tdata[33:2]),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_read_value  (read_value),
    .out_status      (status),
    .out_low_empty   (low_empty),
    .out_high_empty  (high_empty),
    .out_shared_full (shared_full)
  );

  assign out_tdata = {3'b000, shared_full, high_empty, low_empty, status, read_value};

endmodule
